FILE: rtl/slrd_pkg.sv
// ----------------------------------------------------------------------------
// slrd_pkg
// Shared types and constants for the skip/literal run row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package slrd_pkg;

	// fixed field widths
	localparam int BYTE_W     = 8;
	localparam int PORT_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int RUN_W      = 7;

	// code byte layout
	localparam logic [RUN_W-1:0] RUN_MASK = 7'h7F;
	localparam int               SKIP_BIT = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

	// one decoded result
	typedef struct packed {
		logic              pixel_valid;
		logic [PORT_W-1:0] pixel_column;
		logic [PORT_W-1:0] pixel_row;
		logic [BYTE_W-1:0] pixel_value;
		logic              frame_done;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/slrd_core.sv
// ----------------------------------------------------------------------------
// slrd_core
// Decoder state, configuration registers and the per-byte step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module slrd_core
	import slrd_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 step,
	input  wire logic [BYTE_W-1:0]    in_byte,
	output result_t                   result
);

	localparam int CMP_W = PORT_W + 1;

	logic [CFG_W-1:0]       row_bytes_q;
	logic [CFG_W-1:0]       frame_rows_q;
	logic                   lit_q;
	logic [RUN_W-1:0]       left_q;
	logic [COORD_WIDTH-1:0] col_q;
	logic [COORD_WIDTH-1:0] row_q;

	logic                   lit_d;
	logic [RUN_W-1:0]       left_d;
	logic [COORD_WIDTH-1:0] col_d;
	logic [COORD_WIDTH-1:0] row_d;

	logic [COORD_WIDTH-1:0] col_adv;
	logic [COORD_WIDTH-1:0] row_inc;
	logic [RUN_W-1:0]       left_dec;
	logic [RUN_W-1:0]       run;
	logic [RUN_W-1:0]       run_clip;
	logic [CMP_W-1:0]       room;
	logic                   skip;
	logic                   lit_start;
	logic                   row_end;
	logic                   frame_end;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= CFG_W'(1);
			frame_rows_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_BYTES:  row_bytes_q  <= cfg_wdata;
				REG_FRAME_ROWS: frame_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// code byte: clip run to room left in the row
	assign run  = in_byte[RUN_W-1:0] & RUN_MASK;
	assign skip = in_byte[SKIP_BIT];
	assign room = (CMP_W'(col_q) < CMP_W'(row_bytes_q)) ?
		(CMP_W'(row_bytes_q) - CMP_W'(col_q)) : '0;
	assign run_clip  = (CMP_W'(run) > room) ? room[RUN_W-1:0] : run;
	assign lit_start = !skip && (run_clip != '0);

	// literal byte helpers
	assign left_dec = left_q - RUN_W'(1);
	assign row_inc  = row_q + COORD_WIDTH'(1);

	// next column, then row end check
	always_comb begin
		if (lit_q) begin
			col_adv = col_q + COORD_WIDTH'(1);
			row_end = CMP_W'(col_adv) >= CMP_W'(row_bytes_q);
		end else begin
			col_adv = skip ? (col_q + COORD_WIDTH'(run_clip)) : col_q;
			row_end = !lit_start && (CMP_W'(col_adv) >= CMP_W'(row_bytes_q));
		end
	end

	assign frame_end = row_end && (CMP_W'(row_inc) >= CMP_W'(frame_rows_q));

	// next state
	always_comb begin
		if (lit_q) begin
			lit_d  = left_dec != '0;
			left_d = left_dec;
		end else begin
			lit_d  = lit_start;
			left_d = lit_start ? run_clip : left_q;
		end
		col_d = col_adv;
		row_d = row_q;
		if (row_end) begin
			col_d  = '0;
			lit_d  = 1'b0;
			left_d = '0;
			row_d  = frame_end ? '0 : row_inc;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= 1'b0;
			left_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (step) begin
			lit_q  <= lit_d;
			left_q <= left_d;
			col_q  <= col_d;
			row_q  <= row_d;
		end
	end

	// result of this byte
	always_comb begin
		result.pixel_valid  = lit_q;
		result.pixel_column = lit_q ? PORT_W'(col_q) : '0;
		result.pixel_row    = lit_q ? PORT_W'(row_q) : '0;
		result.pixel_value  = lit_q ? in_byte : '0;
		result.frame_done   = frame_end;
	end

endmodule

`default_nettype wire

FILE: rtl/slrd_out_reg.sv
// ----------------------------------------------------------------------------
// slrd_out_reg
// Result register holding one decoded request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slrd_out_reg
	import slrd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result_d,
	input  wire logic    out_stall,
	output logic         out_valid,
	output result_t      result_q
);

	logic valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign out_valid = valid_q;

endmodule

`default_nettype wire

FILE: rtl/skip_literal_rle_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// skip_literal_rle_row_decoder_unit
// Output: the result of an accepted byte is registered and shows at the outputs in the next cycle.
// Throughput: one byte per cycle while in_stall is low; the column/row next state is combinational.
// The input stalls only while a held result is itself stalled.
// Reset: asynchronous; clears decoder state, sets row_bytes and frame_rows to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module skip_literal_rle_row_decoder_unit
	import slrd_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    in_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      pixel_valid,
	output logic [PORT_W-1:0]         pixel_column,
	output logic [PORT_W-1:0]         pixel_row,
	output logic [BYTE_W-1:0]         pixel_value,
	output logic                      frame_done
);

	logic    in_accept;
	result_t step_result;
	result_t held_result;

	// accept while the result register is free or draining
	assign in_stall  = out_valid && out_stall;
	assign in_accept = in_valid && !in_stall;

	slrd_core #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (in_accept),
		.in_byte   (in_byte),
		.result    (step_result)
	);

	slrd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.result_d  (step_result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result_q  (held_result)
	);

	// result fields
	assign pixel_valid  = held_result.pixel_valid;
	assign pixel_column = held_result.pixel_column;
	assign pixel_row    = held_result.pixel_row;
	assign pixel_value  = held_result.pixel_value;
	assign frame_done   = held_result.frame_done;

endmodule

`default_nettype wire
